### design/pemix_pkg.sv
// Shared types and constants for the PCM effects mixer.
// No dependencies; imported by the controller, datapath and top level.
package pemix_pkg;

    localparam int SAMPLE_DEPTH = 16384;
    localparam int ADDR_W       = $clog2(SAMPLE_DEPTH);
    localparam int LEN_W        = 15;
    localparam int SMP_W        = 8;
    localparam int CMD_W        = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 15;
    localparam int TDATA_W      = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_STEP = 2'd0,
        CMD_LOAD_SPIN = 2'd1,
        CMD_MIX       = 2'd2
    } t_cmd_code;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOUND_EN   = 2'd0,
        CFG_EFFECTS_EN = 2'd1,
        CFG_STEP_LEN   = 2'd2,
        CFG_SPIN_LEN   = 2'd3
    } t_cfg_idx;

    // controller -> datapath commands
    typedef struct packed {
        logic load_step;   // write step RAM from the input transaction
        logic load_spin;   // write scaled value into spin RAM
        logic mix_start;   // latch stream sample and flags
        logic rd;          // read both RAMs, advance play positions
        logic mix_first;   // overlay step sample
        logic out_load;    // overlay spin sample into output register
    } t_dp_cmd;

endpackage

### design/pemix_ram.sv
// Generic single-port-write / single-port-read RAM with registered read.
// No dependencies.
module pemix_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/pemix_ctrl.sv
// Mixer controller: input/output handshake and the four-step mix sequence.
// Depends on pemix_pkg.
module pemix_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [pemix_pkg::CMD_W-1:0]   i_in_cmd,
    output logic                          o_in_ready,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output pemix_pkg::t_dp_cmd            o_cmd
);
    import pemix_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_MIX1,
        ST_MIX2
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   accept;
    logic   out_load;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    // output register is free when empty or being drained this cycle
    assign out_load   = (r_state == ST_MIX2) && (!r_out_valid || i_out_ready);

    always_comb begin
        o_cmd = '0;
        if (accept) begin
            case (t_cmd_code'(i_in_cmd))
                CMD_LOAD_STEP: o_cmd.load_step = 1'b1;
                CMD_LOAD_SPIN: o_cmd.load_spin = 1'b1;
                CMD_MIX:       o_cmd.mix_start = 1'b1;
                default:       ;
            endcase
        end
        o_cmd.rd        = (r_state == ST_READ);
        o_cmd.mix_first = (r_state == ST_MIX1);
        o_cmd.out_load  = out_load;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (o_cmd.mix_start) n_state = ST_READ;
            ST_READ: n_state = ST_MIX1;
            ST_MIX1: n_state = ST_MIX2;
            ST_MIX2: if (out_load) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

### design/pemix_dp.sv
// Mixer datapath: configuration registers, sample RAMs, play positions
// and the shared saturating mix unit. Depends on pemix_pkg, pemix_ram.
module pemix_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pemix_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [pemix_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  pemix_pkg::t_dp_cmd                i_cmd,
    input  logic [pemix_pkg::ADDR_W-1:0]      i_load_address,
    input  logic [pemix_pkg::SMP_W-1:0]       i_load_value,
    input  logic [pemix_pkg::SMP_W-1:0]       i_stream_sample,
    input  logic                              i_step_trigger,
    input  logic                              i_motor_on,
    output logic [pemix_pkg::SMP_W-1:0]       o_mixed_sample
);
    import pemix_pkg::*;

    localparam logic [LEN_W-1:0]  DEPTH_LEN = LEN_W'(SAMPLE_DEPTH);
    localparam logic [SMP_W-1:0]  SILENCE   = 8'h80;

    // t = 128*(a+b+128) -/+ a*b + 64, >>7, clamp 0..255
    function automatic logic [SMP_W-1:0] mix_pair(input logic [SMP_W-1:0] x,
                                                  input logic [SMP_W-1:0] y);
        logic signed [7:0]  a;
        logic signed [7:0]  b;
        logic signed [15:0] p;
        logic signed [17:0] t;
        a = {~x[7], x[6:0]};
        b = {~y[7], y[6:0]};
        p = a * b;
        t = ((18'(a) + 18'(b) + 18'sd128) <<< 7) + 18'sd64;
        if (!a[7] && !b[7]) begin
            t = t - 18'(p);
        end else if (a[7] && b[7]) begin
            t = t + 18'(p);
        end
        if (t[17]) begin
            return '0;
        end else if (|t[16:15]) begin
            return 8'hFF;
        end
        return t[14:7];
    endfunction

    logic               r_sound_en;
    logic               r_effects_en;
    logic [LEN_W-1:0]   r_step_len;
    logic [LEN_W-1:0]   r_spin_len;

    logic [SMP_W-1:0]   r_s;
    logic               r_trig;
    logic               r_motor;
    logic [LEN_W-1:0]   r_step_pos;
    logic               r_step_playing;
    logic [ADDR_W-1:0]  r_spin_pos;
    logic               r_pending;
    logic               r_use_step;
    logic               r_use_spin;
    logic [SMP_W-1:0]   r_out;

    logic [LEN_W-1:0]   slen, plen;
    logic               trig_any, step_go, spin_go;
    logic [LEN_W-1:0]   pos_eff, pos_inc, sp_inc;
    logic [ADDR_W-1:0]  sp_eff;
    logic signed [15:0] spin_prod;
    logic [SMP_W-1:0]   spin_scaled;
    logic [SMP_W-1:0]   step_rdata, spin_rdata;
    logic [SMP_W-1:0]   mix_y, mix_res;
    logic               mix_use;

    assign slen = (r_step_len > DEPTH_LEN) ? DEPTH_LEN : r_step_len;
    assign plen = (r_spin_len > DEPTH_LEN) ? DEPTH_LEN : r_spin_len;

    assign trig_any = r_trig || r_pending;
    assign pos_eff  = trig_any ? '0 : r_step_pos;
    assign step_go  = (trig_any || r_step_playing) && (pos_eff < slen);
    assign pos_inc  = pos_eff + LEN_W'(1);

    // a length shrunk under the position restarts the loop at entry 0
    assign sp_eff  = ({1'b0, r_spin_pos} >= plen) ? '0 : r_spin_pos;
    assign spin_go = r_motor && (plen != '0);
    assign sp_inc  = LEN_W'(sp_eff) + LEN_W'(1);

    // spin scaling 51/256 with floor, rebiased by wrapping 0x8000
    assign spin_prod   = 16'($signed({~i_load_value[7], i_load_value[6:0]})) * 16'sd51;
    assign spin_scaled = 8'((16'(spin_prod) + 16'h8000) >> 8);

    pemix_ram #(.WIDTH(SMP_W), .DEPTH(SAMPLE_DEPTH)) u_step_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_step),
        .i_waddr (i_load_address),
        .i_wdata (i_load_value),
        .i_re    (i_cmd.rd),
        .i_raddr (pos_eff[ADDR_W-1:0]),
        .o_rdata (step_rdata)
    );

    pemix_ram #(.WIDTH(SMP_W), .DEPTH(SAMPLE_DEPTH)) u_spin_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_spin),
        .i_waddr (i_load_address),
        .i_wdata (spin_scaled),
        .i_re    (i_cmd.rd),
        .i_raddr (sp_eff),
        .o_rdata (spin_rdata)
    );

    // one mix unit, used for the step overlay and then the spin overlay
    assign mix_y   = i_cmd.mix_first ? step_rdata : spin_rdata;
    assign mix_use = i_cmd.mix_first ? r_use_step : r_use_spin;
    assign mix_res = mix_use ? mix_pair(r_s, mix_y) : r_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sound_en     <= 1'b1;
            r_effects_en   <= 1'b1;
            r_step_len     <= '0;
            r_spin_len     <= '0;
            r_step_pos     <= '0;
            r_step_playing <= 1'b0;
            r_spin_pos     <= '0;
            r_pending      <= 1'b0;
            r_use_step     <= 1'b0;
            r_use_spin     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_addr))
                    CFG_SOUND_EN:   r_sound_en   <= i_cfg_wdata[0];
                    CFG_EFFECTS_EN: r_effects_en <= i_cfg_wdata[0];
                    CFG_STEP_LEN:   r_step_len   <= i_cfg_wdata;
                    CFG_SPIN_LEN:   r_spin_len   <= i_cfg_wdata;
                    default:        ;
                endcase
            end
            if (i_cmd.rd) begin
                if (r_effects_en) begin
                    r_pending      <= 1'b0;
                    r_step_pos     <= step_go ? pos_inc : pos_eff;
                    r_step_playing <= step_go && (pos_inc < slen);
                    r_spin_pos     <= (spin_go && (sp_inc < plen)) ?
                                      sp_inc[ADDR_W-1:0] : '0;
                    r_use_step     <= step_go;
                    r_use_spin     <= spin_go;
                end else begin
                    if (r_trig) begin
                        r_pending <= 1'b1;
                    end
                    r_use_step <= 1'b0;
                    r_use_spin <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mix_start) begin
            r_s     <= r_sound_en ? i_stream_sample : SILENCE;
            r_trig  <= i_step_trigger;
            r_motor <= i_motor_on;
        end else if (i_cmd.mix_first) begin
            r_s <= mix_res;
        end
        if (i_cmd.out_load) begin
            r_out <= mix_res;
        end
    end

    assign o_mixed_sample = r_out;

endmodule

### design/pcm_u8_effects_mixer.sv
// Channel   Dir  Signals                         Contents
// s_axis    in   tvalid/tready/tdata/tuser       load or mix command
// m_axis    out  tvalid/tready/tdata             mixed sample
// i_cfg     in   we/addr/wdata                   mixer registers
//
// A load is written on acceptance. A mix runs: accept, read of both
// sample RAMs, step overlay, spin overlay, the two overlays sharing one
// multiply-and-saturate unit; the last step waits while the output
// register is still full. Reset is synchronous, active low; it clears
// positions, config and handshake state but not the sample RAMs.
//
// Top level of the PCM effects mixer. Depends on pemix_pkg, pemix_ctrl,
// pemix_dp (and through it pemix_ram).
module pcm_u8_effects_mixer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [13:0] load_address, [21:14] load_value, [29:22] stream_sample,
    // [30] step_trigger, [31] motor_on
    input  logic [pemix_pkg::TDATA_W-1:0]     s_axis_tdata,
    // [1:0] cmd
    input  logic [pemix_pkg::CMD_W-1:0]       s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [7:0] mixed_sample
    output logic [pemix_pkg::SMP_W-1:0]       m_axis_tdata,
    input  logic                              i_cfg_we,
    input  logic [pemix_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [pemix_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import pemix_pkg::*;

    t_dp_cmd dp_cmd;

    pemix_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_cmd    (s_axis_tuser),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (dp_cmd)
    );

    pemix_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_cmd           (dp_cmd),
        .i_load_address  (s_axis_tdata[13:0]),
        .i_load_value    (s_axis_tdata[21:14]),
        .i_stream_sample (s_axis_tdata[29:22]),
        .i_step_trigger  (s_axis_tdata[30]),
        .i_motor_on      (s_axis_tdata[31]),
        .o_mixed_sample  (m_axis_tdata)
    );

    // a mix transaction blocks the input until its sequence ends
    a_busy_after_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.mix_start |=> !s_axis_tready)
        else $error("input ready right after mix accept");

    a_mix_sequence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.mix_start |-> ##2 dp_cmd.mix_first)
        else $error("step overlay not two cycles after mix accept");

    a_out_from_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(dp_cmd.out_load))
        else $error("output valid without a finished mix");

    a_no_load_in_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dp_cmd.rd || dp_cmd.mix_first) |-> !(dp_cmd.load_step || dp_cmd.load_spin))
        else $error("sample load during mix sequence");

endmodule

### sim/pcm_u8_effects_mixer_tb.sv
// Self-checking testbench for pcm_u8_effects_mixer: random load/mix traffic with
// random stalls on both stream ports, checked against an in-bench mixer predictor.
// Depends on pemix_pkg and the pcm_u8_effects_mixer RTL.
`timescale 1ns / 100ps

module pcm_u8_effects_mixer_tb;
    import pemix_pkg::*;

    localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;  // unused opcode, block ignores it
    localparam int PRELOAD   = 128;    // entries of each store written before any mix
    localparam int MAX_CYC   = 400000;
    localparam int SETTLE    = 8;
    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        logic [CMD_W-1:0]   op;
        logic [TDATA_W-1:0] data;
    } mix_tx_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [TDATA_W-1:0]    s_axis_tdata = '0;
    logic [CMD_W-1:0]      s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [SMP_W-1:0]      m_axis_tdata;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    pcm_u8_effects_mixer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state
    logic [SMP_W-1:0]      step_buf [SAMPLE_DEPTH];
    logic [SMP_W-1:0]      spin_buf [SAMPLE_DEPTH];
    int                    step_ptr = 0;
    bit                    step_busy = 1'b0;
    int                    spin_ptr = 0;
    bit                    trig_held = 1'b0;
    bit                    snd_on = 1'b1;
    bit                    fx_on = 1'b1;
    logic [LEN_W-1:0]      step_cnt = '0;
    logic [LEN_W-1:0]      spin_cnt = '0;

    mix_tx_t               tx_pending[$];
    logic [SMP_W-1:0]      mixed_due[$];
    int                    n_queued = 0;
    int                    n_taken = 0;
    int                    n_results = 0;
    int                    n_errors = 0;
    int                    n_cycles = 0;
    bit                    src_fast = 1'b0;
    bit                    sink_fast = 1'b0;
    bit                    motor_st = 1'b0;
    int                    src_gap = 0;
    int                    sink_wait = 0;
    int                    hold_left = 0;

    // saturating additive overlay of two biased samples
    function automatic logic [SMP_W-1:0] overlay(input logic [SMP_W-1:0] x,
                                                 input logic [SMP_W-1:0] y);
        int a, b, t;
        a = int'(x) - 128;
        b = int'(y) - 128;
        t = 128 * (a + b + 128) + 64;
        if (a >= 0 && b >= 0)
            t -= a * b;
        else if (a < 0 && b < 0)
            t += a * b;
        if (t < 0)
            t = 0;
        t = t >>> 7;
        if (t > 255)
            t = 255;
        return t[SMP_W-1:0];
    endfunction

    function automatic int clip_len(input logic [LEN_W-1:0] len);
        return (int'(len) > SAMPLE_DEPTH) ? SAMPLE_DEPTH : int'(len);
    endfunction

    task automatic mixer_apply(input logic [CMD_W-1:0] op, input logic [TDATA_W-1:0] d);
        logic [ADDR_W-1:0] addr;
        logic [SMP_W-1:0]  val, s;
        int                p, slen, plen;
        addr = d[13:0];
        val  = d[21:14];
        s    = snd_on ? d[29:22] : 8'd128;
        case (op)
            CMD_LOAD_STEP: step_buf[addr] = val;
            CMD_LOAD_SPIN: begin
                p = (int'(val) - 128) * 51 + 32768;  // 51/256 scale, floor
                spin_buf[addr] = p[15:8];
            end
            CMD_MIX: begin
                if (!fx_on) begin
                    if (d[30])
                        trig_held = 1'b1;
                end else begin
                    slen = clip_len(step_cnt);
                    plen = clip_len(spin_cnt);
                    if (d[30] || trig_held) begin
                        trig_held = 1'b0;
                        step_ptr  = 0;
                        step_busy = 1'b1;
                    end
                    if (step_busy && step_ptr < slen) begin
                        s = overlay(s, step_buf[step_ptr]);
                        step_ptr++;
                        if (step_ptr >= slen)
                            step_busy = 1'b0;
                    end else begin
                        step_busy = 1'b0;
                    end
                    if (d[31] && plen > 0) begin
                        if (spin_ptr >= plen)
                            spin_ptr = 0;
                        s = overlay(s, spin_buf[spin_ptr]);
                        spin_ptr++;
                        if (spin_ptr >= plen)
                            spin_ptr = 0;
                    end else begin
                        spin_ptr = 0;
                    end
                end
                mixed_due.push_back(s);
            end
            default: ;
        endcase
    endtask

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_gap = 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (src_gap != 0) begin
                s_axis_tvalid <= 1'b0;
                src_gap = src_gap - 1;
            end else if (tx_pending.size() != 0) begin
                mix_tx_t tx;
                tx = tx_pending.pop_front();
                s_axis_tuser  <= tx.op;
                s_axis_tdata  <= tx.data;
                s_axis_tvalid <= 1'b1;
                src_gap = src_fast ? 0 : $urandom_range(0, 8);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // output sink: per-result stall, plus two long hold-offs to back up the pipe
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (m_axis_tvalid && m_axis_tready) begin
            if (n_results == 60 || n_results == 150) begin
                m_axis_tready <= 1'b0;
                hold_left = 250;
            end else begin
                if ($urandom_range(0, 39) == 0)
                    sink_fast = !sink_fast;
                sink_wait = sink_fast ? 0 : $urandom_range(0, 8);
                m_axis_tready <= (sink_wait == 0);
                if (sink_wait != 0)
                    sink_wait = sink_wait - 1;
            end
        end else if (sink_wait != 0) begin
            m_axis_tready <= 1'b0;
            sink_wait = sink_wait - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // monitor: check results first, then predict from accepted commands
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_results++;
            if (mixed_due.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_SHOWN)
                    $display("unexpected mixed_sample %0d", m_axis_tdata);
            end else begin
                logic [SMP_W-1:0] want;
                want = mixed_due.pop_front();
                if (m_axis_tdata !== want) begin
                    n_errors++;
                    if (n_errors <= MAX_SHOWN)
                        $display("mixed_sample mismatch: expected %0d, got %0d",
                                 want, m_axis_tdata);
                end
            end
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            mixer_apply(s_axis_tuser, s_axis_tdata);
            n_taken++;
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > MAX_CYC) begin
            $display("timeout");
            $display("pcm_u8_effects_mixer_tb NOT OK");
            $finish;
        end
    end

    task automatic queue_tx(input logic [CMD_W-1:0] op, input logic [TDATA_W-1:0] d);
        mix_tx_t tx;
        tx.op   = op;
        tx.data = d;
        tx_pending.push_back(tx);
        n_queued++;
    endtask

    task automatic load(input logic [CMD_W-1:0] op, input int addr, input int val);
        logic [TDATA_W-1:0] d;
        d = $urandom();
        d[13:0]  = addr[13:0];
        d[21:14] = val[7:0];
        queue_tx(op, d);
    endtask

    task automatic mix(input int smp, input bit trig, input bit motor);
        logic [TDATA_W-1:0] d;
        d = $urandom();
        d[29:22] = smp[7:0];
        d[30]    = trig;
        d[31]    = motor;
        queue_tx(CMD_MIX, d);
    endtask

    // wait until the block is idle with nothing outstanding
    task automatic drain();
        while (n_taken != n_queued || mixed_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val[CFG_DATA_W-1:0];
        case (idx)
            CFG_SOUND_EN:   snd_on   = val[0];
            CFG_EFFECTS_EN: fx_on    = val[0];
            CFG_STEP_LEN:   step_cnt = val[LEN_W-1:0];
            CFG_SPIN_LEN:   spin_cnt = val[LEN_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_all(input int snd, input int fx, input int slen, input int plen);
        write_reg(CFG_SOUND_EN, snd);
        write_reg(CFG_EFFECTS_EN, fx);
        write_reg(CFG_STEP_LEN, slen);
        write_reg(CFG_SPIN_LEN, plen);
    endtask

    // mostly mixes with motor runs and occasional triggers; loads stay in the
    // written region except for a few full-range addresses, plus unused opcodes
    task automatic random_traffic(input int n);
        int r, addr;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            addr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, SAMPLE_DEPTH - 1)
                                               : $urandom_range(0, PRELOAD - 1);
            if (r < 4) begin
                queue_tx(CMD_NONE, $urandom());
            end else if (r < 20) begin
                load(CMD_LOAD_STEP, addr, $urandom_range(0, 255));
            end else if (r < 34) begin
                load(CMD_LOAD_SPIN, addr, $urandom_range(0, 255));
            end else begin
                if ($urandom_range(0, 11) == 0)
                    motor_st = !motor_st;
                mix($urandom_range(0, 255), $urandom_range(0, 15) == 0, motor_st);
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_all(1, 1, 4, 3);

        // fill the start of both stores so no mix reads an unwritten entry
        src_fast = 1'b1;
        load(CMD_LOAD_STEP, 0, 255);
        load(CMD_LOAD_STEP, 1, 0);
        load(CMD_LOAD_STEP, 2, 128);
        load(CMD_LOAD_STEP, 3, 127);
        load(CMD_LOAD_SPIN, 0, 0);
        load(CMD_LOAD_SPIN, 1, 255);
        load(CMD_LOAD_SPIN, 2, 128);
        for (int a = 4; a < PRELOAD; a++)
            load(CMD_LOAD_STEP, a, $urandom_range(0, 255));
        for (int a = 3; a < PRELOAD; a++)
            load(CMD_LOAD_SPIN, a, $urandom_range(0, 255));
        load(CMD_LOAD_STEP, SAMPLE_DEPTH - 1, 255);
        load(CMD_LOAD_SPIN, SAMPLE_DEPTH - 1, 0);
        drain();
        src_fast = 1'b0;

        // directed: full step sound over sample extremes, spin loop, rewind
        mix(0, 1, 1);
        mix(255, 0, 1);
        mix(128, 0, 1);
        mix(255, 0, 1);
        mix(0, 0, 1);
        mix(255, 0, 0);
        queue_tx(CMD_NONE, '1);
        queue_tx(CMD_NONE, '0);
        mix(1, 1, 1);
        mix(254, 0, 1);
        drain();

        // trigger while effects are off is held, then fires on re-enable
        write_reg(CFG_EFFECTS_EN, 0);
        mix(200, 1, 1);
        mix(10, 0, 1);
        drain();
        write_reg(CFG_SOUND_EN, 0);
        mix(77, 0, 1);
        drain();
        write_reg(CFG_EFFECTS_EN, 1);
        mix(99, 0, 1);
        mix(33, 0, 1);
        drain();
        write_reg(CFG_SOUND_EN, 1);

        // spin length shrinks under the current position
        mix(50, 0, 0);
        mix(60, 0, 1);
        mix(70, 0, 1);
        drain();
        write_reg(CFG_SPIN_LEN, 2);
        mix(80, 0, 1);
        drain();

        // empty sounds, then lengths at and beyond the store depth
        write_reg(CFG_STEP_LEN, 0);
        write_reg(CFG_SPIN_LEN, 0);
        mix(90, 1, 1);
        drain();
        write_reg(CFG_STEP_LEN, 32767);
        write_reg(CFG_SPIN_LEN, SAMPLE_DEPTH);
        mix(100, 1, 1);
        mix(110, 0, 1);
        drain();
        write_reg(CFG_STEP_LEN, 1);
        write_reg(CFG_SPIN_LEN, 1);
        mix(120, 1, 1);
        mix(130, 0, 1);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_all(1, 1, $urandom_range(16, 40), $urandom_range(5, 30));
                1: begin
                    src_fast = 1'b1;
                    set_all(1, 1, 1, 1);
                end
                2: set_all(1, 0, 20, 10);
                3: set_all(0, 1, 64, 7);
                4: set_all(1, 1, 32767, SAMPLE_DEPTH);
                default: set_all(1, 1, $urandom_range(0, 120), $urandom_range(0, 120));
            endcase
            random_traffic(45);
            drain();
            src_fast = 1'b0;
        end

        if (n_errors == 0 && mixed_due.size() == 0)
            $display("pcm_u8_effects_mixer_tb OK");
        else
            $display("pcm_u8_effects_mixer_tb NOT OK");
        $finish;
    end

endmodule

### sim.f
design/pemix_pkg.sv
design/pemix_ram.sv
design/pemix_ctrl.sv
design/pemix_dp.sv
design/pcm_u8_effects_mixer.sv
sim/pcm_u8_effects_mixer_tb.sv
